### rtl/gdbd_pkg.sv
// ----------------------------------------------------------------------------
// gdbd_pkg
// Shared types, constants and the month offset table for the Gregorian
// date difference block.
// ----------------------------------------------------------------------------
package gdbd_pkg;

    // Field widths
    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int DNUM_W  = 23;   // day number of any year 0..16383
    localparam int DAYS_W  = 22;   // elapsed days result
    localparam int CORR_W  = 13;   // leap day count plus month correction

    // Saturation value of the result
    localparam logic [DAYS_W-1:0] DAYS_MAX = {DAYS_W{1'b1}};

    // Reciprocal of 25 scaled by 2^17, exact for dividends below 4121
    localparam int          RECIP_SHIFT = 17;
    localparam logic [12:0] RECIP25     = 13'd5243;

    // Months
    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    // Load enables of the three day number stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    // Days before the first of the month in a common year
    function automatic logic [8:0] month_start(input logic [MON_W-1:0] mon);
        logic [8:0] days;
        case (mon)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

### rtl/gdbd_day_num.sv
// ----------------------------------------------------------------------------
// gdbd_day_num
// Three stage pipeline turning one date into a linear day number counted
// from the first of January of year 0.
// ----------------------------------------------------------------------------
module gdbd_day_num (
    input  logic                              i_clk,
    input  gdbd_pkg::t_stage_en               i_en,
    input  logic [gdbd_pkg::DAY_W-1:0]        i_day,
    input  logic [gdbd_pkg::MON_W-1:0]        i_month,
    input  logic [gdbd_pkg::YEAR_W-1:0]       i_year,
    output logic [gdbd_pkg::DNUM_W-1:0]       o_day_num
);
    import gdbd_pkg::*;

    // ---- stage 1: clamp month, divide year by 100 and 400 ----
    logic [MON_W-1:0]  w_mon;
    logic [11:0]       w_q4;
    logic [9:0]        w_q16;
    logic [24:0]       w_prod100;
    logic [22:0]       w_prod400;

    logic [DAY_W-1:0]  r_day;
    logic [MON_W-1:0]  r_month;
    logic [YEAR_W-1:0] r_year;
    logic [7:0]        r_f100;
    logic [5:0]        r_f400;

    always_comb begin
        if (i_month < MON_JAN) begin
            w_mon = MON_JAN;
        end else if (i_month > MON_DEC) begin
            w_mon = MON_DEC;
        end else begin
            w_mon = i_month;
        end
        // y/100 = (y/4)/25 and y/400 = (y/16)/25
        w_q4      = i_year[YEAR_W-1:2];
        w_q16     = i_year[YEAR_W-1:4];
        w_prod100 = 25'(w_q4) * 25'(RECIP25);
        w_prod400 = 23'(w_q16) * 23'(RECIP25);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_day   <= i_day;
            r_month <= w_mon;
            r_year  <= i_year;
            r_f100  <= w_prod100[RECIP_SHIFT +: 8];
            r_f400  <= w_prod400[RECIP_SHIFT +: 6];
        end
    end

    // ---- stage 2: leap tests, leap day count, year and month base ----
    logic              w_z4;
    logic              w_z100;
    logic              w_z400;
    logic              w_leap;
    logic [CORR_W-1:0] w_c4;
    logic [8:0]        w_c100;
    logic [6:0]        w_c400;
    logic [CORR_W-1:0] n_corr;
    logic [DNUM_W-1:0] n_base;

    logic [CORR_W-1:0] r_corr;
    logic [DNUM_W-1:0] r_base;

    always_comb begin
        w_z4   = (r_year[1:0] == 2'd0);
        w_z100 = ((15'(r_f100) * 15'd100) == 15'(r_year));
        w_z400 = ((15'(r_f400) * 15'd400) == 15'(r_year));
        w_leap = (w_z4 && !w_z100) || w_z400;
        // rounded-up quotients count the leap years before this year
        w_c4   = 13'(r_year[YEAR_W-1:2]) + 13'(!w_z4);
        w_c100 = 9'(r_f100) + 9'(!w_z100);
        w_c400 = 7'(r_f400) + 7'(!w_z400);
        n_corr = w_c4 - 13'(w_c100) + 13'(w_c400)
               + 13'(w_leap && (r_month > MON_FEB));
        n_base = 23'(r_year) * 23'd365 + 23'(month_start(r_month)) + 23'(r_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_corr <= n_corr;
            r_base <= n_base;
        end
    end

    // ---- stage 3: final day number ----
    logic [DNUM_W-1:0] r_day_num;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_day_num <= r_base + 23'(r_corr);
        end
    end

    assign o_day_num = r_day_num;

endmodule

### rtl/gdbd_diff.sv
// ----------------------------------------------------------------------------
// gdbd_diff
// Output stage: order check, subtraction and saturation of the two day
// numbers into the result register.
// ----------------------------------------------------------------------------
module gdbd_diff (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [gdbd_pkg::DNUM_W-1:0]   i_start_num,
    input  logic [gdbd_pkg::DNUM_W-1:0]   i_end_num,
    output logic [gdbd_pkg::DAYS_W-1:0]   o_elapsed_days,
    output logic                          o_order_error
);
    import gdbd_pkg::*;

    logic              w_err;
    logic [DNUM_W-1:0] w_diff;
    logic [DAYS_W-1:0] n_days;

    logic [DAYS_W-1:0] r_days;
    logic              r_err;

    // start after end gives zero, long spans saturate
    always_comb begin
        w_err  = (i_start_num > i_end_num);
        w_diff = i_end_num - i_start_num;
        if (w_err) begin
            n_days = '0;
        end else if (w_diff[DNUM_W-1]) begin
            n_days = DAYS_MAX;
        end else begin
            n_days = w_diff[DAYS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_days <= n_days;
            r_err  <= w_err;
        end
    end

    assign o_elapsed_days = r_days;
    assign o_order_error  = r_err;

endmodule

### rtl/gregorian_days_between_dates.sv
// ----------------------------------------------------------------------------
// gregorian_days_between_dates
// Days elapsed between two proleptic Gregorian dates, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: a start
//   date and an end date. Output channel (o_out_valid / i_out_ready)
//   returns the elapsed day count and an order error flag, which is set
//   with a zero count when the start date lies after the end date.
//   From acceptance to o_out_valid a request passes three stages per date
//   (month clamp and divide by 100/400, leap count and year/month base,
//   final sum) and one difference stage.
//   Throughput is one request per cycle while the receiver does not stall;
//   both dates go through their own day number pipeline side by side.
//   Each stage holds a valid bit and loads when it is empty or when the
//   stage after it moves, so bubbles are squeezed out. When the receiver
//   stalls, requests pile up until all four stages are full, then
//   o_in_ready drops; nothing is lost or repeated.
//   Reset (synchronous, active low) clears all valid bits; the pipeline
//   comes out of reset empty and ready.
// ----------------------------------------------------------------------------
module gregorian_days_between_dates (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [gdbd_pkg::DAY_W-1:0]     i_start_day,
    input  logic [gdbd_pkg::MON_W-1:0]     i_start_month,
    input  logic [gdbd_pkg::YEAR_W-1:0]    i_start_year,
    input  logic [gdbd_pkg::DAY_W-1:0]     i_end_day,
    input  logic [gdbd_pkg::MON_W-1:0]     i_end_month,
    input  logic [gdbd_pkg::YEAR_W-1:0]    i_end_year,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [gdbd_pkg::DAYS_W-1:0]    o_elapsed_days,
    output logic                           o_order_error
);
    import gdbd_pkg::*;

    logic      r_v1, r_v2, r_v3, r_v4;
    logic      w_en1, w_en2, w_en3, w_en4;
    t_stage_en w_stage_en;

    logic [DNUM_W-1:0] w_start_num;
    logic [DNUM_W-1:0] w_end_num;

    // stage load enables: a stage moves when empty or when its successor moves
    always_comb begin
        w_en4         = !r_v4 || i_out_ready;
        w_en3         = !r_v3 || w_en4;
        w_en2         = !r_v2 || w_en3;
        w_en1         = !r_v1 || w_en2;
        w_stage_en.s1 = w_en1;
        w_stage_en.s2 = w_en2;
        w_stage_en.s3 = w_en3;
    end

    assign o_in_ready = w_en1;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    gdbd_day_num u_start_num (
        .i_clk     (i_clk),
        .i_en      (w_stage_en),
        .i_day     (i_start_day),
        .i_month   (i_start_month),
        .i_year    (i_start_year),
        .o_day_num (w_start_num)
    );

    gdbd_day_num u_end_num (
        .i_clk     (i_clk),
        .i_en      (w_stage_en),
        .i_day     (i_end_day),
        .i_month   (i_end_month),
        .i_year    (i_end_year),
        .o_day_num (w_end_num)
    );

    gdbd_diff u_diff (
        .i_clk          (i_clk),
        .i_en           (w_en4),
        .i_start_num    (w_start_num),
        .i_end_num      (w_end_num),
        .o_elapsed_days (o_elapsed_days),
        .o_order_error  (o_order_error)
    );

    assign o_out_valid = r_v4;

endmodule

### rtl/gdbd_checker.sv
// ----------------------------------------------------------------------------
// gdbd_checker
// Port level checks on the date difference block, bound to the top level.
// ----------------------------------------------------------------------------
module gdbd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_in_ready,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [gdbd_pkg::DAYS_W-1:0]    o_elapsed_days,
    input  logic                           o_order_error
);
    import gdbd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_elapsed_days) && $stable(o_order_error))
        else $error("result changed while stalled");

    // an order error always reports zero days
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_order_error |-> o_elapsed_days == '0)
        else $error("order error with nonzero day count");

    // back pressure only when the output is held up
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input not ready while output is free");

    // pipeline comes out of reset empty
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

endmodule

bind gregorian_days_between_dates gdbd_checker u_gdbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_elapsed_days (o_elapsed_days),
    .o_order_error  (o_order_error)
);

### tb/gregorian_days_between_dates_tb.sv
// ----------------------------------------------------------------------------
// gregorian_days_between_dates_tb
// Drives date pairs into the Gregorian day difference block and checks
// every returned day count and order flag against an in-bench predictor.
// ----------------------------------------------------------------------------
module gregorian_days_between_dates_tb;

    import gdbd_pkg::*;

    // Expected-result store with its own day count predictor
    class gdbd_scoreboard;

        typedef struct {
            logic [DAYS_W-1:0] days;
            logic              err;
        } t_span;

        t_span       span_q[$];
        int unsigned fail_count;
        int unsigned checked;
        int unsigned order_errs;
        int unsigned saturated;

        function new();
            fail_count = 0;
            checked    = 0;
            order_errs = 0;
            saturated  = 0;
        endfunction

        // Days before the first of the month, common year
        function int unsigned days_before(int unsigned mon);
            case (mon)
                2:       return 31;
                3:       return 59;
                4:       return 90;
                5:       return 120;
                6:       return 151;
                7:       return 181;
                8:       return 212;
                9:       return 243;
                10:      return 273;
                11:      return 304;
                12:      return 334;
                default: return 0;
            endcase
        endfunction

        // Day number counted from 1 January of year 0
        function int unsigned day_count(logic [DAY_W-1:0] d, logic [MON_W-1:0] m,
                                        logic [YEAR_W-1:0] y);
            int unsigned yr;
            int unsigned mon;
            int unsigned n;
            bit          leap;
            yr  = 32'(y);
            mon = 32'(m);
            if (mon < 1)
                mon = 1;
            if (mon > 12)
                mon = 12;
            // leap years among 0..yr-1
            n    = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
            leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
            n    = n + days_before(mon);
            if (mon > 2 && leap)
                n = n + 1;
            return n + 32'(d);
        endfunction

        // Work out the result of an accepted request and queue it
        function void note_request(logic [DAY_W-1:0] sd, logic [MON_W-1:0] sm,
                                   logic [YEAR_W-1:0] sy, logic [DAY_W-1:0] ed,
                                   logic [MON_W-1:0] em, logic [YEAR_W-1:0] ey);
            int unsigned a;
            int unsigned b;
            int unsigned diff;
            t_span       s;
            a = day_count(sd, sm, sy);
            b = day_count(ed, em, ey);
            if (a > b) begin
                s.days = '0;
                s.err  = 1'b1;
                order_errs++;
            end else begin
                diff = b - a;
                if (diff > DAYS_MAX) begin
                    diff = DAYS_MAX;
                    saturated++;
                end
                s.days = diff[DAYS_W-1:0];
                s.err  = 1'b0;
            end
            span_q.push_back(s);
        endfunction

        // Compare a returned result with the oldest expectation
        function void check_result(logic [DAYS_W-1:0] days, logic err);
            t_span s;
            if (span_q.size() == 0) begin
                $error("unexpected result: elapsed_days %0d order_error %0b", days, err);
                fail_count++;
                return;
            end
            s = span_q.pop_front();
            checked++;
            if (days !== s.days) begin
                $error("elapsed_days: expected %0d, actual %0d", s.days, days);
                fail_count++;
            end
            if (err !== s.err) begin
                $error("order_error: expected %0b, actual %0b", s.err, err);
                fail_count++;
            end
        endfunction

        function int pending();
            return span_q.size();
        endfunction

    endclass

    localparam int RAND_REQS = 1930;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic [DAY_W-1:0]    i_start_day   = '0;
    logic [MON_W-1:0]    i_start_month = '0;
    logic [YEAR_W-1:0]   i_start_year  = '0;
    logic [DAY_W-1:0]    i_end_day     = '0;
    logic [MON_W-1:0]    i_end_month   = '0;
    logic [YEAR_W-1:0]   i_end_year    = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [DAYS_W-1:0]   o_elapsed_days;
    logic                o_order_error;

    gdbd_scoreboard      sb;
    int unsigned         idle_pct = 33;
    int unsigned         sent     = 0;

    gregorian_days_between_dates i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .i_end_day      (i_end_day),
        .i_end_month    (i_end_month),
        .i_end_year     (i_end_year),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_elapsed_days (o_elapsed_days),
        .o_order_error  (o_order_error)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: take results and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_elapsed_days, o_order_error);
        i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Present one request, with random idle cycles ahead of it
    task automatic send_dates(input logic [DAY_W-1:0] sd, input logic [MON_W-1:0] sm,
                              input logic [YEAR_W-1:0] sy, input logic [DAY_W-1:0] ed,
                              input logic [MON_W-1:0] em, input logic [YEAR_W-1:0] ey);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_start_day   <= sd;
        i_start_month <= sm;
        i_start_year  <= sy;
        i_end_day     <= ed;
        i_end_month   <= em;
        i_end_year    <= ey;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_request(sd, sm, sy, ed, em, ey);
        sent++;
    endtask

    // One random request; mostly ordinary in-range dates
    task automatic send_random();
        logic [DAY_W-1:0]  sd;
        logic [DAY_W-1:0]  ed;
        logic [MON_W-1:0]  sm;
        logic [MON_W-1:0]  em;
        logic [YEAR_W-1:0] sy;
        logic [YEAR_W-1:0] ey;
        int unsigned       kind;
        kind = $urandom_range(99);
        sd   = DAY_W'($urandom_range(1, ($urandom_range(9) == 0) ? 31 : 28));
        ed   = DAY_W'($urandom_range(1, ($urandom_range(9) == 0) ? 31 : 28));
        sm   = MON_W'($urandom_range(1, 12));
        em   = MON_W'($urandom_range(1, 12));
        sy   = YEAR_W'($urandom_range(1583, 9999));
        ey   = YEAR_W'($urandom_range(1583, 9999));
        if (kind < 20) begin
            // close together: same or neighbouring year
            ey = sy + YEAR_W'($urandom_range(1));
            if (ey > 9999)
                ey = 9999;
        end else if (kind < 30) begin
            // equal dates
            ed = sd;
            em = sm;
            ey = sy;
        end else if (kind < 85) begin
            // pair with random content, mostly put in order below
        end else begin
            // raw bit patterns, out-of-range values included
            sd = DAY_W'($urandom);
            ed = DAY_W'($urandom);
            sm = MON_W'($urandom);
            em = MON_W'($urandom);
            sy = YEAR_W'($urandom);
            ey = YEAR_W'($urandom);
        end
        // keep most random-content pairs in order; a share stays reversed
        if (kind < 85 && kind >= 30 && $urandom_range(99) < 80 &&
            sb.day_count(sd, sm, sy) > sb.day_count(ed, em, ey)) begin
            send_dates(ed, em, ey, sd, sm, sy);
        end else begin
            send_dates(sd, sm, sy, ed, em, ey);
        end
    endtask

    // Run time limit
    initial begin
        #8000000;
        $display("gregorian_days_between_dates_tb: FAIL");
        $finish;
    end

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: range ends, leap rules and out-of-range fields
        send_dates(5'd1, 4'd1, 14'd1583, 5'd31, 4'd12, 14'd9999);
        send_dates(5'd15, 4'd6, 14'd2000, 5'd15, 4'd6, 14'd2000);
        send_dates(5'd31, 4'd12, 14'd9999, 5'd1, 4'd1, 14'd1583);
        send_dates(5'd2, 4'd1, 14'd2024, 5'd1, 4'd1, 14'd2024);
        send_dates(5'd28, 4'd2, 14'd1600, 5'd1, 4'd3, 14'd1600);
        send_dates(5'd28, 4'd2, 14'd1700, 5'd1, 4'd3, 14'd1700);
        send_dates(5'd28, 4'd2, 14'd2000, 5'd1, 4'd3, 14'd2000);
        send_dates(5'd28, 4'd2, 14'd2023, 5'd1, 4'd3, 14'd2024);
        send_dates(5'd31, 4'd12, 14'd1899, 5'd1, 4'd1, 14'd1900);
        send_dates(5'd10, 4'd0, 14'd2001, 5'd10, 4'd1, 14'd2001);
        send_dates(5'd10, 4'd12, 14'd2001, 5'd10, 4'd15, 14'd2001);
        send_dates(5'd0, 4'd3, 14'd2010, 5'd1, 4'd3, 14'd2010);
        send_dates(5'd30, 4'd4, 14'd2010, 5'd31, 4'd4, 14'd2010);
        send_dates(5'd31, 4'd4, 14'd2010, 5'd1, 4'd5, 14'd2010);
        send_dates(5'd28, 4'd2, 14'd0, 5'd1, 4'd3, 14'd0);
        send_dates(5'd31, 4'd12, 14'd0, 5'd1, 4'd1, 14'd1);
        send_dates(5'd0, 4'd0, 14'd0, 5'd31, 4'd15, 14'd16383);
        send_dates(5'd1, 4'd1, 14'd5000, 5'd31, 4'd12, 14'd16383);
        send_dates(5'd31, 4'd15, 14'd16383, 5'd0, 4'd0, 14'd0);
        send_dates(5'd1, 4'd1, 14'd1583, 5'd2, 4'd1, 14'd1583);
        send_dates(5'd1, 4'd3, 14'd9999, 5'd1, 4'd3, 14'd9998);

        // Random part, with a stretch of back-to-back traffic
        for (int i = 0; i < RAND_REQS; i++) begin
            idle_pct = (i >= 700 && i < 1000) ? 0 : 33;
            send_random();
        end
        i_in_valid <= 1'b0;

        // Drain and let the pipeline settle
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d of %0d date pairs: %0d start-after-end, %0d saturated.",
                 sb.checked, sent, sb.order_errs, sb.saturated);
        if (sb.fail_count == 0) begin
            $display("gregorian_days_between_dates_tb: PASS");
        end else begin
            $display("gregorian_days_between_dates_tb: FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/gdbd_pkg.sv
rtl/gdbd_day_num.sv
rtl/gdbd_diff.sv
rtl/gregorian_days_between_dates.sv
rtl/gdbd_checker.sv
tb/gregorian_days_between_dates_tb.sv
